### rtl/lsa_pkg.sv
// ============================================================================
// lsa_pkg: shared types and constants of the LIFO stack allocator
// Request and response beat layouts, opcode and status codes, frame entry
// layout and the fixed arithmetic constants of the allocator.
// ============================================================================
package lsa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_MARK   = 2'd2,
      OP_REWIND = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_NON_LIFO   = 3'd2,
      ST_FRAMES_FULL = 3'd3,
      ST_BAD_MARKER = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] alloc_size;
      logic [3:0]  align_log2;
      logic [31:0] handle_in;
      logic [31:0] rewind_marker;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] handle_out;
      logic [31:0] used_bytes;
      logic [31:0] peak_bytes;
      logic [31:0] alloc_count;
      logic [31:0] failed_count;
      logic [31:0] free_count;
   } rsp_type;

   // One pushed frame: the top and last handle in force before the allocate.
   typedef struct packed {
      logic        saved_valid;
      logic [31:0] saved_handle;
      logic [31:0] saved_top;
   } frame_entry_type;

   localparam logic [31:0] ARENA_RESET = 32'd65536;
   localparam logic [34:0] HDR_BYTES   = 35'd16;
   localparam logic [34:0] HDR_ALIGN_MASK = 35'd7;

endpackage

### rtl/lsa_frame_store.sv
// ============================================================================
// lsa_frame_store: frame stack memory
// Single-port-write, single-port-read synchronous memory holding one frame
// entry per pushed allocation. Read data is registered.
// ============================================================================
module lsa_frame_store #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  lsa_pkg::frame_entry_type      wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output lsa_pkg::frame_entry_type      rd_data
);

   lsa_pkg::frame_entry_type mem [DEPTH];
   lsa_pkg::frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lifo_stack_allocator_unit.sv
// ============================================================================
// lifo_stack_allocator_unit: bump allocator with a LIFO frame stack
// Serves allocate, free, mark and rewind requests against an arena whose
// capacity is set through the CSR port, one response beat per request.
// ============================================================================
// An accepted request moves to the execute state, and the response beat is
// registered as that state ends. A new request is taken only in idle; busy is
// high for the one execute cycle, set by the frame store read that a free must
// see before it writes back. The receiver cannot stall responses.
// Reset is synchronous: state, counters and capacity return to their reset
// values; the frame store needs no clearing pass.
module lifo_stack_allocator_unit #(
   parameter int ADDR_BITS  = 32,
   parameter int MAX_FRAMES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lsa_pkg::req_type req_data,
   output logic             rsp_valid,
   output lsa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata
);

   localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W   = (ADDR_BITS > 32) ? ADDR_BITS : 32;
   localparam logic [LIM_W-1:0] ADDR_LIMIT = (LIM_W'(1) << ADDR_BITS) - LIM_W'(1);
   localparam logic [31:0] RESET_CAP =
      (LIM_W'(lsa_pkg::ARENA_RESET) < ADDR_LIMIT) ? lsa_pkg::ARENA_RESET
                                                  : ADDR_LIMIT[31:0];
   localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(MAX_FRAMES);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type           state_ff;
   logic [31:0]         cap_ff, cap_in;
   logic [31:0]         top_ff, top_in;
   logic [31:0]         last_handle_ff, last_handle_in;
   logic                last_valid_ff, last_valid_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [31:0]         peak_ff, peak_in;
   logic [31:0]         alloc_cnt_ff, alloc_cnt_in;
   logic [31:0]         failed_cnt_ff, failed_cnt_in;
   logic [31:0]         free_cnt_ff, free_cnt_in;
   logic                rsp_valid_ff;
   lsa_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   lsa_pkg::req_type    req_ff;
   logic [34:0]         payload_ff, payload_in;

   logic [34:0]         hdr_c;
   logic [34:0]         align_mask_c;
   logic [34:0]         new_top_c;
   logic                accept_c;

   logic                      frame_wr_en;
   lsa_pkg::frame_entry_type  frame_wr_data;
   lsa_pkg::frame_entry_type  frame_rd_data;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   assign accept_c = start && (state_ff == S_IDLE);
   assign busy     = (state_ff == S_EXEC);

   // Payload placement is worked out while the request is accepted, so for an
   // allocate the execute cycle only adds the size and checks capacity and depth.
   always_comb begin
      hdr_c = ({3'b000, top_ff} + lsa_pkg::HDR_ALIGN_MASK) & ~lsa_pkg::HDR_ALIGN_MASK;
      align_mask_c = {19'd0, (16'd1 << req_data.align_log2) - 16'd1};
      payload_in = (hdr_c + lsa_pkg::HDR_BYTES + align_mask_c) & ~align_mask_c;
   end

   assign cap_in = (LIM_W'(csr_wdata) < ADDR_LIMIT) ? csr_wdata : ADDR_LIMIT[31:0];
   assign new_top_c = payload_ff + {3'b000, req_ff.alloc_size};

   always_comb begin
      top_in         = top_ff;
      last_handle_in = last_handle_ff;
      last_valid_in  = last_valid_ff;
      depth_in       = depth_ff;
      peak_in        = peak_ff;
      alloc_cnt_in   = alloc_cnt_ff;
      failed_cnt_in  = failed_cnt_ff;
      free_cnt_in    = free_cnt_ff;
      frame_wr_en    = 1'b0;
      frame_wr_data  = '{saved_valid: last_valid_ff,
                         saved_handle: last_handle_ff,
                         saved_top: top_ff};
      rsp_data_in            = '0;
      rsp_data_in.status     = lsa_pkg::ST_OK;
      case (req_ff.opcode)
         lsa_pkg::OP_ALLOC: begin
            alloc_cnt_in = sat_inc(alloc_cnt_ff);
            if (new_top_c > {3'b000, cap_ff}) begin
               rsp_data_in.status = lsa_pkg::ST_NO_SPACE;
               failed_cnt_in      = sat_inc(failed_cnt_ff);
            end else if (depth_ff >= FULL_DEPTH) begin
               rsp_data_in.status = lsa_pkg::ST_FRAMES_FULL;
               failed_cnt_in      = sat_inc(failed_cnt_ff);
            end else begin
               frame_wr_en    = busy;
               depth_in       = depth_ff + DEPTH_W'(1);
               top_in         = new_top_c[31:0];
               last_handle_in = payload_ff[31:0];
               last_valid_in  = 1'b1;
               if (new_top_c[31:0] > peak_ff) begin
                  peak_in = new_top_c[31:0];
               end
               rsp_data_in.handle_out = payload_ff[31:0];
            end
         end
         lsa_pkg::OP_FREE: begin
            free_cnt_in = sat_inc(free_cnt_ff);
            if (!last_valid_ff || (req_ff.handle_in != last_handle_ff) ||
                (depth_ff == '0)) begin
               rsp_data_in.status = lsa_pkg::ST_NON_LIFO;
            end else begin
               depth_in       = depth_ff - DEPTH_W'(1);
               top_in         = frame_rd_data.saved_top;
               last_handle_in = frame_rd_data.saved_handle;
               last_valid_in  = frame_rd_data.saved_valid;
            end
         end
         lsa_pkg::OP_REWIND: begin
            if (req_ff.rewind_marker > top_ff) begin
               rsp_data_in.status = lsa_pkg::ST_BAD_MARKER;
            end else begin
               top_in         = req_ff.rewind_marker;
               last_handle_in = '0;
               last_valid_in  = 1'b0;
               depth_in       = '0;
            end
         end
         default: begin
            // Mark only reports the current top.
         end
      endcase
      rsp_data_in.used_bytes   = top_in;
      rsp_data_in.peak_bytes   = peak_in;
      rsp_data_in.alloc_count  = alloc_cnt_in;
      rsp_data_in.failed_count = failed_cnt_in;
      rsp_data_in.free_count   = free_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cap_ff         <= RESET_CAP;
         top_ff         <= '0;
         last_handle_ff <= '0;
         last_valid_ff  <= 1'b0;
         depth_ff       <= '0;
         peak_ff        <= '0;
         alloc_cnt_ff   <= '0;
         failed_cnt_ff  <= '0;
         free_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         rsp_valid_ff <= (state_ff == S_EXEC);
         if (csr_we) begin
            cap_ff <= cap_in;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept_c) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff       <= S_IDLE;
               top_ff         <= top_in;
               last_handle_ff <= last_handle_in;
               last_valid_ff  <= last_valid_in;
               depth_ff       <= depth_in;
               peak_ff        <= peak_in;
               alloc_cnt_ff   <= alloc_cnt_in;
               failed_cnt_ff  <= failed_cnt_in;
               free_cnt_ff    <= free_cnt_in;
               rsp_data_ff    <= rsp_data_in;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept_c) begin
         req_ff     <= req_data;
         payload_ff <= payload_in;
      end
   end

   // The read of the top frame is issued with the accept; a push from the
   // previous request has already been written by then.
   lsa_frame_store #(
      .DEPTH (MAX_FRAMES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (frame_wr_en),
      .wr_addr (IDX_W'(depth_ff)),
      .wr_data (frame_wr_data),
      .rd_en   (accept_c),
      .rd_addr (IDX_W'(depth_ff - DEPTH_W'(1))),
      .rd_data (frame_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/lsa_checker.sv
// ============================================================================
// lsa_checker: port-level checks of the allocator's command timing and error handles
// Watches start, busy and the response beat, and is bound to the allocator unit.
// ============================================================================
module lsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lsa_pkg::rsp_type rsp_data
);

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_valid)
      else $error("execute cycle not followed by a response beat");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response beat without a preceding execute cycle");

   a_handle_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != lsa_pkg::ST_OK) |-> rsp_data.handle_out == '0)
      else $error("failed request returned a nonzero handle");

endmodule

bind lifo_stack_allocator_unit lsa_checker u_lsa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/lsa_arena_tracker.sv
`timescale 1ns / 100ps
// ============================================================================
// lsa_arena_tracker: response predictor and scoreboard for the stack allocator
// Watches the request, response and CSR ports of the allocator, keeps its own
// copy of the arena state, predicts one response beat per accepted request and
// compares every response beat field by field against the oldest prediction.
// ============================================================================
module lsa_arena_tracker
   import lsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          beats_pending,
   output logic [31:0] top_hint,
   output logic [31:0] handle_hint
);

   localparam int FRAME_SLOTS = 64;

   logic [31:0] arena_cap;
   logic [31:0] top_off;
   logic [31:0] grant_handle;
   logic        grant_valid;
   int unsigned frame_cnt;
   logic [31:0] saved_top   [FRAME_SLOTS];
   logic [31:0] saved_grant [FRAME_SLOTS];
   logic        saved_valid [FRAME_SLOTS];
   logic [31:0] peak_top;
   logic [31:0] n_alloc;
   logic [31:0] n_failed;
   logic [31:0] n_free;
   rsp_type     expected_beats[$];
   int          errors = 0;

   assign mismatch_count = errors;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   task automatic predict_beat(input req_type r, output rsp_type e);
      logic [63:0] hdr;
      logic [63:0] amask;
      logic [63:0] payload;
      logic [63:0] new_top;
      e = '0;
      e.status = ST_OK;
      case (r.opcode)
         OP_ALLOC: begin
            hdr     = ({32'd0, top_off} + 64'd7) & ~64'd7;
            amask   = (64'd1 << r.align_log2) - 64'd1;
            payload = (hdr + 64'd16 + amask) & ~amask;
            new_top = payload + {32'd0, r.alloc_size};
            n_alloc = sat_inc(n_alloc);
            // With 32 address bits the address limit never binds below the capacity.
            if (new_top > {32'd0, arena_cap}) begin
               e.status = ST_NO_SPACE;
               n_failed = sat_inc(n_failed);
            end else if (frame_cnt >= FRAME_SLOTS) begin
               e.status = ST_FRAMES_FULL;
               n_failed = sat_inc(n_failed);
            end else begin
               saved_top[frame_cnt]   = top_off;
               saved_grant[frame_cnt] = grant_handle;
               saved_valid[frame_cnt] = grant_valid;
               frame_cnt++;
               top_off      = new_top[31:0];
               grant_handle = payload[31:0];
               grant_valid  = 1'b1;
               if (top_off > peak_top) peak_top = top_off;
               e.handle_out = payload[31:0];
            end
         end
         OP_FREE: begin
            n_free = sat_inc(n_free);
            if (!grant_valid || r.handle_in != grant_handle || frame_cnt == 0) begin
               e.status = ST_NON_LIFO;
            end else begin
               frame_cnt--;
               top_off      = saved_top[frame_cnt];
               grant_handle = saved_grant[frame_cnt];
               grant_valid  = saved_valid[frame_cnt];
            end
         end
         OP_REWIND: begin
            if (r.rewind_marker > top_off) begin
               e.status = ST_BAD_MARKER;
            end else begin
               top_off      = r.rewind_marker;
               grant_handle = '0;
               grant_valid  = 1'b0;
               frame_cnt    = 0;
            end
         end
         default: ;
      endcase
      e.used_bytes   = top_off;
      e.peak_bytes   = peak_top;
      e.alloc_count  = n_alloc;
      e.failed_count = n_failed;
      e.free_count   = n_free;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         arena_cap    = ARENA_RESET;
         top_off      = '0;
         grant_handle = '0;
         grant_valid  = 1'b0;
         frame_cnt    = 0;
         peak_top     = '0;
         n_alloc      = '0;
         n_failed     = '0;
         n_free       = '0;
         expected_beats.delete();
      end else begin
         // Compare first so that a beat never meets the prediction made at the same edge.
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: response beat expected none actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               check_field("status", {29'd0, want.status}, {29'd0, rsp_data.status});
               check_field("handle_out", want.handle_out, rsp_data.handle_out);
               check_field("used_bytes", want.used_bytes, rsp_data.used_bytes);
               check_field("peak_bytes", want.peak_bytes, rsp_data.peak_bytes);
               check_field("alloc_count", want.alloc_count, rsp_data.alloc_count);
               check_field("failed_count", want.failed_count, rsp_data.failed_count);
               check_field("free_count", want.free_count, rsp_data.free_count);
            end
         end
         if (csr_we) arena_cap = csr_wdata;
         if (start && !busy) begin
            predict_beat(req_data, fresh);
            expected_beats.push_back(fresh);
         end
      end
      beats_pending <= expected_beats.size();
      top_hint      <= top_off;
      handle_hint   <= grant_handle;
   end

endmodule

### tb/tb_lifo_stack_allocator_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_lifo_stack_allocator_unit: stimulus and verdict for the stack allocator
// Drives directed and random allocate, free, mark and rewind requests with
// random idle gaps across several arena capacities; the arena tracker beside
// the block predicts and checks every response beat.
// ============================================================================
module tb_lifo_stack_allocator_unit;
   import lsa_pkg::*;

   localparam int MAX_GAP     = 17;
   localparam int STALL_LIMIT = 400;
   localparam int PHASE_BEATS = 140;

   typedef enum {FIX_NONE, FIX_FREE_LAST, FIX_REWIND_OK, FIX_REWIND_BAD, FIX_FILL} fixup_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [31:0] csr_wdata;

   int          mismatches;
   int          beats_pending;
   logic [31:0] top_hint;
   logic [31:0] handle_hint;

   logic [31:0] arena_now;
   int          items_sent;
   bit          back_to_back;
   int          idle_cycles;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lifo_stack_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lsa_arena_tracker tracker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .beats_pending  (beats_pending),
      .top_hint       (top_hint),
      .handle_hint    (handle_hint)
   );

   // Any accepted request, response beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic req_type make_req(input opcode_type op, input logic [31:0] size,
                                        input logic [3:0] align, input logic [31:0] hin,
                                        input logic [31:0] marker);
      req_type r;
      r.opcode        = op;
      r.alloc_size    = size;
      r.align_log2    = align;
      r.handle_in     = hin;
      r.rewind_marker = marker;
      return r;
   endfunction

   // Fix-ups that depend on the tracker state are applied only after an idle
   // gap, so the hints already include the previous beat.
   task automatic send_beat(input req_type r, input fixup_type fix);
      int          gap;
      logic [32:0] wide;
      logic [31:0] room;
      gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (fix != FIX_NONE && gap == 0) gap = 1;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      case (fix)
         FIX_FREE_LAST: r.handle_in = handle_hint;
         FIX_REWIND_OK: begin
            case ($urandom_range(0, 3))
               0: r.rewind_marker = '0;
               1: r.rewind_marker = top_hint;
               default: r.rewind_marker = $urandom_range(0, top_hint);
            endcase
         end
         FIX_REWIND_BAD: begin
            wide = {1'b0, top_hint} + 33'd1 + 33'($urandom_range(0, 255));
            r.rewind_marker = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
         end
         FIX_FILL: begin
            r.align_log2 = 4'($urandom_range(0, 3));
            if ({1'b0, arena_now} > {1'b0, top_hint} + 33'd40) begin
               room = arena_now - top_hint;
               r.alloc_size = room - 32'($urandom_range(16, 40));
            end else begin
               r.alloc_size = $urandom_range(0, 64);
            end
         end
         default: ;
      endcase
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
   endtask

   task automatic write_arena(input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      arena_now = value;
   endtask

   function automatic req_type small_alloc();
      logic [31:0] size;
      logic [3:0]  align;
      size  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 64);
      align = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(7, 15))
                                          : 4'($urandom_range(0, 6));
      return make_req(OP_ALLOC, size, align, $urandom, $urandom);
   endfunction

   function automatic req_type noise_req();
      logic [31:0] size;
      case ($urandom_range(0, 3))
         0: size = '0;
         1: size = '1;
         2: size = $urandom_range(0, 4096);
         default: size = $urandom;
      endcase
      return make_req(opcode_type'($urandom_range(0, 3)), size, 4'($urandom_range(0, 15)),
                      ($urandom_range(0, 1) != 0) ? handle_hint : $urandom, $urandom);
   endfunction

   // Push a run of frames, then pop up to one more than were pushed, mostly in LIFO order.
   task automatic nest_sequence();
      int depth;
      int pops;
      depth = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 6);
      for (int i = 0; i < depth; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_beat(small_alloc(), FIX_FILL);
         else
            send_beat(small_alloc(), FIX_NONE);
         if ($urandom_range(0, 15) == 0)
            send_beat(make_req(OP_MARK, $urandom, 4'($urandom), $urandom, $urandom), FIX_NONE);
      end
      pops = $urandom_range(0, depth + 1);
      for (int i = 0; i < pops; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(make_req(OP_FREE, $urandom, 4'($urandom), handle_hint ^ $urandom, $urandom),
                      FIX_NONE);
         else
            send_beat(make_req(OP_FREE, $urandom, 4'($urandom), '0, $urandom), FIX_FREE_LAST);
      end
   endtask

   task automatic rewind_sequence();
      if ($urandom_range(0, 3) == 0)
         send_beat(make_req(OP_REWIND, $urandom, 4'($urandom), $urandom, '0), FIX_REWIND_BAD);
      else
         send_beat(make_req(OP_REWIND, $urandom, 4'($urandom), $urandom, '0), FIX_REWIND_OK);
      send_beat(make_req(OP_MARK, $urandom, 4'($urandom), $urandom, $urandom), FIX_NONE);
   endtask

   task automatic run_phase(input int quota);
      int stop_at;
      int pick;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         back_to_back = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            nest_sequence();
         end else if (pick < 75) begin
            rewind_sequence();
         end else begin
            repeat ($urandom_range(1, 4)) send_beat(noise_req(), FIX_NONE);
         end
      end
   endtask

   task automatic directed_checks();
      send_beat(make_req(OP_MARK, '0, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_MARK, '1, 4'hF, '1, '1), FIX_NONE);
      // Free and rewind against an empty arena.
      send_beat(make_req(OP_FREE, '0, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_REWIND, '0, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_REWIND, '0, 4'd0, '0, 32'd1), FIX_NONE);
      // Minimal allocate, then large alignments and an oversized request.
      send_beat(make_req(OP_ALLOC, '0, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_ALLOC, 32'd100, 4'd12, '0, '0), FIX_NONE);
      send_beat(make_req(OP_ALLOC, 32'd5, 4'd15, '0, '0), FIX_NONE);
      send_beat(make_req(OP_ALLOC, '1, 4'd0, '0, '0), FIX_NONE);
      // A free of an older payload is out of order.
      send_beat(make_req(OP_FREE, '0, 4'd0, 32'd16, '0), FIX_NONE);
      send_beat(make_req(OP_FREE, '0, 4'd0, '0, '0), FIX_FREE_LAST);
      send_beat(make_req(OP_MARK, '0, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_ALLOC, '0, 4'd13, '0, '0), FIX_NONE);
      send_beat(make_req(OP_REWIND, '0, 4'd0, '0, '1), FIX_NONE);
      send_beat(make_req(OP_REWIND, '0, 4'd0, '0, 32'd100), FIX_NONE);
      send_beat(make_req(OP_FREE, '0, 4'd0, 32'd8192, '0), FIX_NONE);
      // From a top of 100 the payload lands at 120, so this fills the arena exactly.
      send_beat(make_req(OP_ALLOC, 32'd65416, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_ALLOC, '0, 4'd0, '0, '0), FIX_NONE);
      send_beat(make_req(OP_FREE, '0, 4'd0, '0, '0), FIX_FREE_LAST);
      send_beat(make_req(OP_ALLOC, '0, 4'd14, '0, '0), FIX_NONE);
      send_beat(make_req(OP_REWIND, '0, 4'd0, '0, 32'd16384), FIX_NONE);
      send_beat(make_req(OP_ALLOC, 32'd64, 4'd3, '1, '1), FIX_NONE);
      send_beat(make_req(OP_FREE, '1, 4'hF, '0, '1), FIX_FREE_LAST);
   endtask

   initial begin
      logic [31:0] arena_plan [7];
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      items_sent   = 0;
      back_to_back = 1'b0;
      arena_now    = ARENA_RESET;
      arena_plan   = '{32'hFFFF_FFFF, 32'd0, 32'd256, 32'd4096, 32'h0010_0000,
                       ARENA_RESET, 32'hFFFF_FFFF};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_checks();
      drain_responses();
      write_arena(32'd0);
      send_beat(make_req(OP_ALLOC, '0, 4'd0, '0, '0), FIX_NONE);

      foreach (arena_plan[i]) begin
         drain_responses();
         // A random mid-range capacity in place of the fifth planned one.
         if (i == 4) arena_plan[i] = $urandom_range(32'h0000_1000, 32'h0100_0000);
         write_arena(arena_plan[i]);
         run_phase(PHASE_BEATS);
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && beats_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lsa_pkg.sv
rtl/lsa_frame_store.sv
rtl/lifo_stack_allocator_unit.sv
rtl/lsa_checker.sv
tb/lsa_arena_tracker.sv
tb/tb_lifo_stack_allocator_unit.sv
